FILE: hw/rtl/dac_channel_shadow_and_frame_builder_defines.svh
// Assertion macros shared by the DAC frame builder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DAC_CHANNEL_SHADOW_AND_FRAME_BUILDER_DEFINES_SVH
`define DAC_CHANNEL_SHADOW_AND_FRAME_BUILDER_DEFINES_SVH
// Same-cycle implication under synchronous reset.
`define DCSF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcsf assertion failed");
// Next-cycle implication under synchronous reset.
`define DCSF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcsf assertion failed");
`endif

FILE: hw/rtl/dcsf_pkg.sv
// Types, codes and span tables for the DAC frame builder.
// No dependencies.
`default_nettype none
package dcsf_pkg;
   localparam int DCSF_CHANNELS = 16;
   localparam int QDEPTH = 2;

   localparam logic [3:0] OP_SPAN = 4'd0;
   localparam logic [3:0] OP_SPAN_ALL = 4'd1;
   localparam logic [3:0] OP_CODE = 4'd2;
   localparam logic [3:0] OP_VOLT = 4'd3;
   localparam logic [3:0] OP_PDOWN = 4'd5;
   localparam logic [3:0] OP_PDOWN_ALL = 4'd6;
   localparam logic [3:0] OP_MUX_ON = 4'd7;
   localparam logic [3:0] OP_MUX_OFF = 4'd8;

   localparam logic [2:0] K_NONE = 3'd0;
   localparam logic [2:0] K_SPAN = 3'd1;
   localparam logic [2:0] K_SPAN_ALL = 3'd2;
   localparam logic [2:0] K_CODE = 3'd3;
   localparam logic [2:0] K_VOLT = 3'd4;
   localparam logic [2:0] K_OTHER = 3'd5;

   localparam logic [3:0] CMD_SPAN = 4'h6;
   localparam logic [3:0] CMD_SPAN_ALL = 4'hE;
   localparam logic [3:0] CMD_CODE = 4'h3;
   localparam logic [3:0] CMD_PDOWN = 4'h4;
   localparam logic [3:0] CMD_PDOWN_ALL = 4'h5;
   localparam logic [3:0] CMD_MUX = 4'hB;

   // ceil(2^22 / 5); exact floor division by five for values below 2^19.
   localparam logic [19:0] RECIP5 = 20'd838861;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] cmd;
      logic [15:0] data;
      logic [3:0] ch;
      logic [3:0] span;
      logic signed [20:0] volts;
      logic [23:0] echo;
   } item_type;

   function automatic logic signed [21:0] span_lo_volts(input logic [3:0] s);
      case (s)
         4'd2: span_lo_volts = -22'sd327680;
         4'd3: span_lo_volts = -22'sd655360;
         4'd4: span_lo_volts = -22'sd163840;
         default: span_lo_volts = 22'sd0;
      endcase
   endfunction

   function automatic logic signed [21:0] span_hi_volts(input logic [3:0] s);
      case (s)
         4'd0: span_hi_volts = 22'sd327680;
         4'd1: span_hi_volts = 22'sd655360;
         4'd2: span_hi_volts = 22'sd327680;
         4'd3: span_hi_volts = 22'sd655360;
         4'd4: span_hi_volts = 22'sd163840;
         default: span_hi_volts = 22'sd0;
      endcase
   endfunction

   // Span width is five times 2^(16 + shift); the multiple is width / 65536.
   function automatic logic [1:0] span_shift(input logic [3:0] s);
      case (s)
         4'd1, 4'd2: span_shift = 2'd1;
         4'd3: span_shift = 2'd2;
         default: span_shift = 2'd0;
      endcase
   endfunction

   function automatic logic [4:0] span_mult(input logic [3:0] s);
      case (s)
         4'd0, 4'd4: span_mult = 5'd5;
         4'd1, 4'd2: span_mult = 5'd10;
         4'd3: span_mult = 5'd20;
         default: span_mult = 5'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/dac_channel_shadow_and_frame_builder.sv
// Each accepted request waits in the queue until the back end loads it in IDLE; the back end then
// steps through SCALE, DIV, WRITE, READ and OUT, which registers the result. It takes a new request
// only from IDLE; a 2-entry request queue lets start be taken while the back end works.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset clears the queue, the sequencer, all channel shadows (span 0, code 0),
// the last frame and the verified flag.
`default_nettype none
module dac_channel_shadow_and_frame_builder import dcsf_pkg::*; #(
   parameter int CHANNELS = DCSF_CHANNELS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [3:0] req_operation,
   input wire logic [3:0] req_channel,
   input wire logic [3:0] req_span,
   input wire logic [15:0] req_code,
   input wire logic signed [20:0] req_volts,
   input wire logic [23:0] req_echo,
   output logic rsp_strobe,
   output logic rsp_frame_sent,
   output logic [23:0] rsp_frame,
   output logic rsp_verified,
   output logic [15:0] rsp_code_out,
   output logic signed [20:0] rsp_volts_out
);
   logic q_valid, q_pop;
   item_type q_item;

   dcsf_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_channel(req_channel), .req_span(req_span),
      .req_code(req_code), .req_volts(req_volts), .req_echo(req_echo),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   dcsf_back #(.CHANNELS(CHANNELS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_strobe(rsp_strobe), .rsp_frame_sent(rsp_frame_sent), .rsp_frame(rsp_frame),
      .rsp_verified(rsp_verified), .rsp_code_out(rsp_code_out),
      .rsp_volts_out(rsp_volts_out)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/dcsf_front.sv
// Front end: decodes each request into a command byte and data, and queues it.
// Depends on dcsf_pkg.
`default_nettype none
module dcsf_front import dcsf_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [3:0] req_operation,
   input wire logic [3:0] req_channel,
   input wire logic [3:0] req_span,
   input wire logic [15:0] req_code,
   input wire logic signed [20:0] req_volts,
   input wire logic [23:0] req_echo,
   output logic q_valid,
   output item_type q_item,
   input wire logic q_pop
);
   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   item_type slot_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   item_type dec;
   logic push;

   always_comb begin
      dec = '0;
      dec.ch = req_channel;
      dec.span = req_span;
      dec.volts = req_volts;
      dec.echo = req_echo;
      case (req_operation)
         OP_SPAN: begin
            dec.kind = K_SPAN; dec.cmd = {CMD_SPAN, req_channel};
            dec.data = {12'd0, req_span};
         end
         OP_SPAN_ALL: begin
            dec.kind = K_SPAN_ALL; dec.cmd = {CMD_SPAN_ALL, 4'd0};
            dec.data = {12'd0, req_span};
         end
         OP_CODE: begin
            dec.kind = K_CODE; dec.cmd = {CMD_CODE, req_channel}; dec.data = req_code;
         end
         OP_VOLT: begin
            dec.kind = K_VOLT; dec.cmd = {CMD_CODE, req_channel};
         end
         OP_PDOWN: begin
            dec.kind = K_OTHER; dec.cmd = {CMD_PDOWN, req_channel};
         end
         OP_PDOWN_ALL: begin
            dec.kind = K_OTHER; dec.cmd = {CMD_PDOWN_ALL, 4'd0};
         end
         OP_MUX_ON: begin
            dec.kind = K_OTHER; dec.cmd = {CMD_MUX, 4'd0};
            dec.data = {11'd0, 1'b1, req_channel};
         end
         OP_MUX_OFF: begin
            dec.kind = K_OTHER; dec.cmd = {CMD_MUX, 4'd0};
         end
         default: dec.kind = K_NONE;
      endcase
   end

   assign busy = (cnt_ff == CW'(QDEPTH));
   assign push = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (q_pop) rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff + CW'(push) - CW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= dec;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/dcsf_back.sv
// Back end: scales voltages, keeps the channel shadows, builds frames and results.
// Depends on dcsf_pkg and the shared assertion macros.
`default_nettype none
`include "dac_channel_shadow_and_frame_builder_defines.svh"
module dcsf_back import dcsf_pkg::*; #(
   parameter int CHANNELS = DCSF_CHANNELS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   input wire item_type q_item,
   output logic q_pop,
   output logic rsp_strobe,
   output logic rsp_frame_sent,
   output logic [23:0] rsp_frame,
   output logic rsp_verified,
   output logic [15:0] rsp_code_out,
   output logic signed [20:0] rsp_volts_out
);
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_DIV = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff;
   item_type it_ff;
   logic [3:0] span_ff [CHANNELS];
   logic [15:0] code_ff [CHANNELS];
   logic [23:0] last_ff;
   logic have_last_ff, verified_ff;
   logic [18:0] nh_ff;
   logic [17:0] nl_ff;
   logic [1:0] sh_ff;
   logic zr_ff;
   logic [38:0] prod_ff;
   logic sent_ff;
   logic [23:0] frame_ff;
   logic [20:0] p_ff;
   logic signed [21:0] lo_ff;
   logic [15:0] code_rd_ff;
   logic strobe_ff;
   logic [23:0] rframe_ff;
   logic rsent_ff, rver_ff;
   logic [15:0] rcode_ff;
   logic signed [20:0] rvolts_ff;

   logic ok;
   logic [IW-1:0] idx;
   logic [3:0] sp_ch;
   logic signed [21:0] lo, hi, vcl, dd;
   logic [36:0] nn;
   logic [16:0] q;
   logic [18:0] r19;
   logic [20:0] rem, den;
   logic [17:0] lmask;
   logic up;
   logic [15:0] cval, data;
   logic [23:0] frame;
   logic sends;
   logic [5:0] q1;
   logic [16:0] r1;
   logic up2;
   logic signed [22:0] vsum;

   assign ok = ({1'b0, it_ff.ch} < 5'(CHANNELS));
   assign idx = it_ff.ch[IW-1:0];
   assign sp_ch = ok ? span_ff[idx] : 4'd0;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   // Clamp and scale: code = D * 65535 / (5 * 2^(16 + shift)).
   always_comb begin
      lo = span_lo_volts(sp_ch);
      hi = span_hi_volts(sp_ch);
      vcl = 22'(it_ff.volts);
      if (vcl < lo) vcl = lo;
      if (vcl > hi) vcl = hi;
      dd = vcl - lo;
      nn = ({16'd0, dd[20:0]} << 16) - {16'd0, dd[20:0]};
   end

   always_comb begin
      q = prod_ff[38:22];
      r19 = nh_ff - 19'(q * 3'd5);
      lmask = 18'((19'd1 << (5'd16 + 5'(sh_ff))) - 19'd1);
      rem = (21'(r19[2:0]) << (5'd16 + 5'(sh_ff))) | 21'(nl_ff & lmask);
      den = 21'(21'd5 << (5'd16 + 5'(sh_ff)));
      up = ({rem, 1'b0} > {1'b0, den});
      cval = zr_ff ? 16'd0 : 16'(q + 17'(up));
      data = (it_ff.kind == K_VOLT) ? cval : it_ff.data;
      frame = {it_ff.cmd, data};
      sends = (it_ff.kind != K_NONE);
   end

   // Readback: volts = P + round(P / 65535) + min, where P = code * width / 65536.
   always_comb begin
      q1 = {1'b0, p_ff[20:16]};
      r1 = 17'(p_ff[15:0]) + 17'(p_ff[20:16]);
      if (r1 >= 17'd65535) begin
         q1 = q1 + 6'd1;
         r1 = r1 - 17'd65535;
      end
      up2 = (r1 > 17'd32767);
      vsum = 23'(p_ff) + 23'(q1) + 23'(up2) + 23'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         strobe_ff <= 1'b0;
         have_last_ff <= 1'b0;
         verified_ff <= 1'b0;
         last_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            span_ff[i] <= '0;
            code_ff[i] <= '0;
         end
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  it_ff <= q_item;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               nh_ff <= nn[16 + 32'(span_shift(sp_ch)) +: 19];
               nl_ff <= nn[17:0];
               sh_ff <= span_shift(sp_ch);
               zr_ff <= (sp_ch > 4'd4);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               prod_ff <= 39'(nh_ff * RECIP5);
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               sent_ff <= sends;
               frame_ff <= sends ? frame : 24'd0;
               if (sends) begin
                  verified_ff <= have_last_ff && (it_ff.echo == last_ff);
                  last_ff <= frame;
                  have_last_ff <= 1'b1;
               end
               case (it_ff.kind)
                  K_SPAN: if (ok) span_ff[idx] <= it_ff.span;
                  K_SPAN_ALL: begin
                     for (int i = 0; i < CHANNELS; i++) span_ff[i] <= it_ff.span;
                  end
                  K_CODE, K_VOLT: if (ok) code_ff[idx] <= data;
                  default: ;
               endcase
               state_ff <= ST_READ;
            end
            ST_READ: begin
               code_rd_ff <= ok ? code_ff[idx] : 16'd0;
               p_ff <= ok ? 21'(code_ff[idx] * span_mult(span_ff[idx])) : 21'd0;
               lo_ff <= ok ? span_lo_volts(span_ff[idx]) : 22'sd0;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               strobe_ff <= 1'b1;
               rsent_ff <= sent_ff;
               rframe_ff <= frame_ff;
               rver_ff <= verified_ff;
               rcode_ff <= code_rd_ff;
               rvolts_ff <= 21'(vsum);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_frame_sent = rsent_ff;
   assign rsp_frame = rframe_ff;
   assign rsp_verified = rver_ff;
   assign rsp_code_out = rcode_ff;
   assign rsp_volts_out = rvolts_ff;

   `DCSF_ASSERT_NXT(a_strobe_after_out, clock, reset, state_ff == ST_OUT, strobe_ff)
   `DCSF_ASSERT_IMP(a_strobe_in_idle, clock, reset, strobe_ff, state_ff == ST_IDLE)
   `DCSF_ASSERT_IMP(a_no_frame_zero, clock, reset, strobe_ff && !rsent_ff, rframe_ff == 24'd0)
   `DCSF_ASSERT_IMP(a_sent_has_last, clock, reset, strobe_ff && rsent_ff,
                    have_last_ff && last_ff == rframe_ff)
endmodule
`default_nettype wire

FILE: verif/dac_channel_shadow_and_frame_builder_test.sv
// Self-checking testbench for the DAC channel shadow and frame builder.
// Depends on dcsf_pkg and the block's RTL; predicts each result and compares it.
`default_nettype none
module dac_channel_shadow_and_frame_builder_test import dcsf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] OP_READ_VOLT = 4'd4;
   localparam int FULL_CODE = 65535;

   typedef struct {
      logic [3:0] operation;
      logic [3:0] channel;
      logic [3:0] span;
      logic [15:0] code;
      logic signed [20:0] volts;
      logic [23:0] echo;
   } request_type;

   typedef struct {
      logic frame_sent;
      logic [23:0] frame;
      logic verified;
      logic [15:0] code_out;
      logic signed [20:0] volts_out;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_operation = '0;
   logic [3:0] req_channel = '0;
   logic [3:0] req_span = '0;
   logic [15:0] req_code = '0;
   logic signed [20:0] req_volts = '0;
   logic [23:0] req_echo = '0;
   logic rsp_strobe;
   logic rsp_frame_sent;
   logic [23:0] rsp_frame;
   logic rsp_verified;
   logic [15:0] rsp_code_out;
   logic signed [20:0] rsp_volts_out;

   request_type pending_requests[$];
   response_type expected_responses[$];
   int mismatches = 0;
   int gap_left = 0;

   // Shadow copy of the DAC state.
   logic [3:0] shadow_span[16];
   logic [15:0] shadow_code[16];
   logic [23:0] shadow_last_frame;
   logic shadow_have_last;
   logic shadow_verified;

   // Last frame of the queued stimulus, used to build matching echoes.
   logic [23:0] shadow_model_last = '0;

   dac_channel_shadow_and_frame_builder i_dut (.*);

   always #2 clock = ~clock;

   function automatic longint span_low(input logic [3:0] s);
      case (s)
         4'd2: return -327680;
         4'd3: return -655360;
         4'd4: return -163840;
         default: return 0;
      endcase
   endfunction

   function automatic longint span_high(input logic [3:0] s);
      case (s)
         4'd0, 4'd2: return 327680;
         4'd1, 4'd3: return 655360;
         4'd4: return 163840;
         default: return 0;
      endcase
   endfunction

   function automatic longint div_half_down(input longint num, input longint den);
      longint q;
      if (den == 0) return 0;
      q = num / den;
      if (2 * (num % den) > den) q++;
      return q;
   endfunction

   function automatic logic [15:0] volts_to_dac_code(input longint v, input logic [3:0] s);
      longint lo, hi, q;
      lo = span_low(s);
      hi = span_high(s);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      q = div_half_down((v - lo) * FULL_CODE, hi - lo);
      if (q > FULL_CODE) q = FULL_CODE;
      return q[15:0];
   endfunction

   function automatic longint dac_code_to_volts(input logic [15:0] c, input logic [3:0] s);
      return div_half_down(longint'(c) * (span_high(s) - span_low(s)), FULL_CODE)
         + span_low(s);
   endfunction

   function automatic logic [23:0] emit_frame(input logic [3:0] cmd, input logic [3:0] addr,
                                              input logic [15:0] data, input logic [23:0] echo);
      logic [23:0] f;
      f = {cmd, addr, data};
      shadow_verified = shadow_have_last && (echo == shadow_last_frame);
      shadow_last_frame = f;
      shadow_have_last = 1'b1;
      return f;
   endfunction

   function automatic response_type predict_response(input request_type r);
      response_type p;
      logic [15:0] c;
      p.frame_sent = 1'b1;
      p.frame = '0;
      case (r.operation)
         OP_SPAN: begin
            p.frame = emit_frame(CMD_SPAN, r.channel, {12'd0, r.span}, r.echo);
            shadow_span[r.channel] = r.span;
         end
         OP_SPAN_ALL: begin
            p.frame = emit_frame(CMD_SPAN_ALL, 4'd0, {12'd0, r.span}, r.echo);
            for (int i = 0; i < 16; i++) shadow_span[i] = r.span;
         end
         OP_CODE: begin
            shadow_code[r.channel] = r.code;
            p.frame = emit_frame(CMD_CODE, r.channel, r.code, r.echo);
         end
         OP_VOLT: begin
            c = volts_to_dac_code(longint'(r.volts), shadow_span[r.channel]);
            shadow_code[r.channel] = c;
            p.frame = emit_frame(CMD_CODE, r.channel, c, r.echo);
         end
         OP_PDOWN: p.frame = emit_frame(CMD_PDOWN, r.channel, 16'd0, r.echo);
         OP_PDOWN_ALL: p.frame = emit_frame(CMD_PDOWN_ALL, 4'd0, 16'd0, r.echo);
         OP_MUX_ON: p.frame = emit_frame(CMD_MUX, 4'd0, {12'd1, r.channel}, r.echo);
         OP_MUX_OFF: p.frame = emit_frame(CMD_MUX, 4'd0, 16'd0, r.echo);
         default: p.frame_sent = 1'b0;
      endcase
      p.verified = shadow_verified;
      p.code_out = shadow_code[r.channel];
      p.volts_out = 21'(dac_code_to_volts(shadow_code[r.channel], shadow_span[r.channel]));
      return p;
   endfunction

   function automatic int random_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Driver: accepted when start is high and busy is low at the edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            void'(pending_requests.pop_front());
            expected_responses.push_back(predict_response(request_type'{req_operation,
               req_channel, req_span, req_code, req_volts, req_echo}));
            gap_left = random_gap();
         end
         if (start && busy) begin
            // Hold the current request.
         end else if (gap_left > 0 || pending_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            start <= 1'b0;
         end else begin
            request_type n;
            n = pending_requests[0];
            start <= 1'b1;
            req_operation <= n.operation;
            req_channel <= n.channel;
            req_span <= n.span;
            req_code <= n.code;
            req_volts <= n.volts;
            req_echo <= n.echo;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         response_type e;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response frame=%h", rsp_frame);
         end else begin
            e = expected_responses.pop_front();
            if (rsp_frame_sent !== e.frame_sent || rsp_frame !== e.frame ||
                rsp_verified !== e.verified || rsp_code_out !== e.code_out ||
                rsp_volts_out !== e.volts_out) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp sent=%b frame=%h ver=%b code=%h volts=%0d",
                     e.frame_sent, e.frame, e.verified, e.code_out, e.volts_out);
                  $display("          act sent=%b frame=%h ver=%b code=%h volts=%0d",
                     rsp_frame_sent, rsp_frame, rsp_verified, rsp_code_out, rsp_volts_out);
               end
            end
         end
      end
   end

   function automatic request_type random_request();
      request_type r;
      int k;
      r.operation = $urandom_range(0, 99) < 5 ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
      r.channel = 4'($urandom);
      r.span = $urandom_range(0, 9) < 8 ? 4'($urandom_range(0, 4)) : 4'($urandom);
      r.code = 16'($urandom);
      k = $urandom_range(0, 9);
      if (k < 6) r.volts = 21'($signed($urandom_range(0, 1400000)) - 700000);
      else r.volts = 21'($urandom);
      // Mostly echo the last frame so the verified flag sees both values.
      r.echo = $urandom_range(0, 3) != 0 ? shadow_model_last : 24'($urandom);
      return r;
   endfunction

   task automatic queue_request(input request_type r);
      pending_requests.push_back(r);
      // Voltage frames are not tracked here, so echoes after them rarely match.
      case (r.operation)
         OP_SPAN: shadow_model_last = {CMD_SPAN, r.channel, 12'd0, r.span};
         OP_SPAN_ALL: shadow_model_last = {CMD_SPAN_ALL, 4'd0, 12'd0, r.span};
         OP_CODE: shadow_model_last = {CMD_CODE, r.channel, r.code};
         OP_PDOWN: shadow_model_last = {CMD_PDOWN, r.channel, 16'd0};
         OP_PDOWN_ALL: shadow_model_last = {CMD_PDOWN_ALL, 20'd0};
         OP_MUX_ON: shadow_model_last = {CMD_MUX, 4'd0, 12'd1, r.channel};
         OP_MUX_OFF: shadow_model_last = {CMD_MUX, 20'd0};
         default: ;
      endcase
   endtask

   function automatic request_type make_request(input logic [3:0] op, input logic [3:0] ch,
                                                input logic [3:0] sp, input logic [15:0] cd,
                                                input logic signed [20:0] v,
                                                input logic [23:0] ec);
      request_type r;
      r = '{op, ch, sp, cd, v, ec};
      return r;
   endfunction

   initial begin
      for (int i = 0; i < 16; i++) begin
         shadow_span[i] = '0;
         shadow_code[i] = '0;
      end
      shadow_last_frame = '0;
      shadow_have_last = 1'b0;
      shadow_verified = 1'b0;
      // Directed part: every operation, field extremes, zero range, echo check.
      queue_request(make_request(OP_READ_VOLT, 4'd0, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_CODE, 4'd0, 4'd0, 16'hFFFF, 21'sd0, 24'd0));
      queue_request(make_request(OP_CODE, 4'd15, 4'd0, 16'h0000, 21'sd0, 24'h30FFFF));
      queue_request(make_request(OP_SPAN, 4'd3, 4'd3, 16'd0, 21'sd0, 24'hFFFFFF));
      queue_request(make_request(OP_VOLT, 4'd3, 4'd0, 16'd0, -21'sd1048576, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd3, 4'd0, 16'd0, 21'sd1048575, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd3, 4'd0, 16'd0, 21'sd5, 24'd0));
      queue_request(make_request(OP_SPAN_ALL, 4'd9, 4'd2, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd7, 4'd0, 16'd0, 21'sd1, 24'd0));
      queue_request(make_request(OP_SPAN, 4'd7, 4'd4, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd7, 4'd0, 16'd0, -21'sd163841, 24'd0));
      queue_request(make_request(OP_SPAN, 4'd8, 4'd15, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd8, 4'd0, 16'd0, 21'sd300000, 24'd0));
      queue_request(make_request(OP_SPAN, 4'd9, 4'd5, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_SPAN, 4'd10, 4'd1, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_VOLT, 4'd10, 4'd0, 16'd0, 21'sd327680, 24'd0));
      queue_request(make_request(OP_PDOWN, 4'd15, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_PDOWN_ALL, 4'd5, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_MUX_ON, 4'd15, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(OP_MUX_OFF, 4'd2, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(4'd15, 4'd10, 4'd0, 16'd0, 21'sd0, 24'd0));
      queue_request(make_request(4'd9, 4'd10, 4'd0, 16'd0, 21'sd0, 24'd0));
      repeat (1800) queue_request(random_request());
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_requests.size() == 0 && !start);
      wait (expected_responses.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0)
         $display("dac_channel_shadow_and_frame_builder_test: PASS");
      else
         $display("dac_channel_shadow_and_frame_builder_test: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("dac_channel_shadow_and_frame_builder_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
